>>> hw/rtl/ffta_pkg.sv
`default_nettype none

package ffta_pkg;

	// default sizes
	localparam int MAX_REGIONS_DEF = 32;
	localparam int TILE_SPACE_DEF  = 2048;

	// field widths
	localparam int MODE_W      = 2;
	localparam int START_W     = 11;
	localparam int LEN_W       = 12;
	localparam int POS_W       = 13;
	localparam int STATUS_W    = 2;
	localparam int ENTRY_CNT_W = 6;

	// stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
	localparam logic [LEN_W-1:0]     LIMIT_RESET = 12'd2048;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_NOP     = 2'd3
	} mode_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOREGION = 2'd2,
		ST_NOFIT    = 2'd3
	} status_e;

	// one table entry
	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] start;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan;
		logic    shift_load;
		logic    shift;
		logic    finish;
		status_e status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic is_release;
		logic full;
		logic zero_count;
		logic hit;
		logic scan_end;
		logic fit_ok;
		logic shift_done;
	} stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/first_fit_tile_allocator.sv
`default_nettype none

// First-fit tile allocator.
// Input stream (s_*): one request word per transfer, mode in s_tuser
// (allocate, release, clear). Output stream (m_*): exactly one result word
// per request with the start tile, a status code and the entry count.
// Config port: cfg_we/cfg_addr/cfg_data write base_tile (0) and tile_limit (1);
// write only while no request is in flight.
// One request at a time. An allocate's scan reads one entry per cycle and
// stops at the slot, then the entries above it move up one per cycle; a
// release moves the entries above its hit down. A request that finds
// nothing ends after the scan; clear and requests rejected up front skip
// the scan. The region table gives one read per cycle.
// s_tready is high only between requests. A finished result sits in the
// output register; the next request is accepted and worked on while it
// waits, and only its own result waits for m_tready.
// Reset empties the table (fill count to zero), sets base_tile to 0 and
// tile_limit to 2048; table contents are not cleared.
module first_fit_tile_allocator #(
	parameter int MAX_REGIONS = ffta_pkg::MAX_REGIONS_DEF,
	parameter int TILE_SPACE  = ffta_pkg::TILE_SPACE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// config write port
	input  wire logic                             cfg_we,
	input  wire logic [ffta_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [ffta_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [11:0] tile_count, [22:12] release_start, [23] zero
	input  wire logic [ffta_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  wire logic [ffta_pkg::MODE_W-1:0]      s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [10:0] start_tile, [12:11] status, [18:13] entry_count, [23:19] zero
	output logic [ffta_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import ffta_pkg::*;

	localparam int OUT_PAD_W = OUT_TDATA_W - START_W - STATUS_W - ENTRY_CNT_W;

	cmd_t                   cmd;
	stat_t                  stat;
	logic [START_W-1:0]     start_tile;
	status_e                status;
	logic [ENTRY_CNT_W-1:0] entry_count;

	ffta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffta_dpath #(
		.MAX_REGIONS (MAX_REGIONS),
		.TILE_SPACE  (TILE_SPACE)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.in_mode     (s_tuser),
		.in_count    (s_tdata[LEN_W-1:0]),
		.in_where    (s_tdata[LEN_W +: START_W]),
		.cmd         (cmd),
		.stat        (stat),
		.start_tile  (start_tile),
		.status      (status),
		.entry_count (entry_count)
	);

	// pack the result word
	assign m_tdata = {{OUT_PAD_W{1'b0}}, entry_count, status, start_tile};

endmodule

`default_nettype wire

>>> hw/rtl/ffta_ctrl.sv
`default_nettype none

module ffta_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire ffta_pkg::stat_t stat,
	output ffta_pkg::cmd_t       cmd
);
	import ffta_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t  state_q, state_d;
	status_e status_q, status_d;
	logic    out_valid_q, out_valid_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		cmd         = '0;
		cmd.status  = status_q;
		state_d     = state_q;
		status_d    = status_q;
		out_valid_d = out_valid_q & ~out_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (!stat.is_alloc && !stat.is_release) begin
					// clear and unused mode finish at once
					status_d = ST_OK;
					state_d  = S_DONE;
				end else if (stat.is_alloc && stat.full) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else if (stat.is_alloc && stat.zero_count) begin
					status_d = ST_NOFIT;
					state_d  = S_DONE;
				end else begin
					cmd.scan = 1'b1;
					if (stat.hit || stat.scan_end) begin
						priority if (stat.is_release && !stat.hit) begin
							status_d = ST_NOREGION;
							state_d  = S_DONE;
						end else if (stat.is_alloc && !stat.fit_ok) begin
							status_d = ST_NOFIT;
							state_d  = S_DONE;
						end else begin
							cmd.shift_load = 1'b1;
							state_d        = S_SHIFT;
						end
					end
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_done) begin
					status_d = ST_OK;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			status_q    <= status_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ffta_dpath.sv
`default_nettype none

module ffta_dpath #(
	parameter int MAX_REGIONS = ffta_pkg::MAX_REGIONS_DEF,
	parameter int TILE_SPACE  = ffta_pkg::TILE_SPACE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ffta_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire logic [ffta_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [ffta_pkg::MODE_W-1:0]        in_mode,
	input  wire logic [ffta_pkg::LEN_W-1:0]         in_count,
	input  wire logic [ffta_pkg::START_W-1:0]       in_where,
	input  wire ffta_pkg::cmd_t                     cmd,
	output ffta_pkg::stat_t                         stat,
	output logic [ffta_pkg::START_W-1:0]            start_tile,
	output ffta_pkg::status_e                       status,
	output logic [ffta_pkg::ENTRY_CNT_W-1:0]        entry_count
);
	import ffta_pkg::*;

	localparam int AW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);

	// configuration
	logic [START_W-1:0] base_q;
	logic [LEN_W-1:0]   limit_q;
	logic [POS_W-1:0]   limit_eff;

	// request held for the whole operation
	mode_e              mode_q;
	logic [LEN_W-1:0]   count_q;
	logic [START_W-1:0] where_q;
	logic [POS_W-1:0]   pos_q;

	// table
	entry_t             mem [MAX_REGIONS];
	entry_t             rdata_q;
	logic [CW-1:0]      total_q;

	// scan and shift counters
	logic [CW-1:0]      ridx_q;
	logic [CW-1:0]      eidx_q;
	logic               dvalid_q;
	logic [CW-1:0]      sk_q;
	logic [CW-1:0]      sk_m1;
	logic               wv_s1;
	logic [AW-1:0]      wa_s1;

	logic               is_alloc, is_release;
	logic [POS_W-1:0]   cand_start, cand_end, pos_cnt;
	logic               match, scan_rd, shift_more, shift_done;
	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr;
	entry_t             wr_data;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BASE:  base_q  <= cfg_data[START_W-1:0];
				REG_LIMIT: limit_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// limit clipped to the tile space
	assign limit_eff = (32'(limit_q) > TILE_SPACE) ? POS_W'(TILE_SPACE) : POS_W'(limit_q);

	assign is_alloc   = (mode_q == MODE_ALLOC);
	assign is_release = (mode_q == MODE_RELEASE);

	// scan compare on the entry read last cycle
	assign cand_start = POS_W'(rdata_q.start);
	assign cand_end   = cand_start + POS_W'(rdata_q.len);
	assign pos_cnt    = pos_q + POS_W'(count_q);
	assign match      = is_alloc ? (cand_start >= pos_cnt) : (rdata_q.start == where_q);
	assign scan_rd    = (ridx_q < total_q);

	// shift: up from the top for insert, down from the hit for removal
	assign sk_m1      = sk_q - 1'b1;
	assign shift_more = is_alloc ? (sk_q > eidx_q) : (sk_q < total_q);
	assign shift_done = ~wv_s1 & ~shift_more;

	// memory ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ridx_q[AW-1:0];
		if (cmd.scan) begin
			rd_en = scan_rd;
		end else if (cmd.shift) begin
			rd_en   = shift_more;
			rd_addr = is_alloc ? sk_m1[AW-1:0] : sk_q[AW-1:0];
		end
	end

	assign wr_en   = cmd.shift & (wv_s1 | (shift_done & is_alloc));
	assign wr_addr = wv_s1 ? wa_s1 : eidx_q[AW-1:0];
	assign wr_data = wv_s1 ? rdata_q : entry_t'{len: count_q, start: pos_q[START_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// status to the controller
	always_comb begin
		stat            = '0;
		stat.is_alloc   = is_alloc;
		stat.is_release = is_release;
		stat.full       = (total_q >= CW'(MAX_REGIONS));
		stat.zero_count = (count_q == '0);
		stat.hit        = dvalid_q & match;
		stat.scan_end   = ~dvalid_q & (eidx_q == total_q);
		stat.fit_ok     = (pos_cnt <= limit_eff);
		stat.shift_done = shift_done;
	end

	// counters and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			ridx_q   <= '0;
			eidx_q   <= '0;
			dvalid_q <= 1'b0;
			sk_q     <= '0;
			wv_s1    <= 1'b0;
			wa_s1    <= '0;
		end else begin
			if (cmd.load) begin
				ridx_q   <= '0;
				eidx_q   <= '0;
				dvalid_q <= 1'b0;
			end
			if (cmd.scan) begin
				dvalid_q <= scan_rd;
				if (scan_rd) begin
					ridx_q <= ridx_q + 1'b1;
				end
				if (dvalid_q && !match) begin
					eidx_q <= eidx_q + 1'b1;
				end
			end
			if (cmd.shift_load) begin
				sk_q  <= is_alloc ? total_q : eidx_q + 1'b1;
				wv_s1 <= 1'b0;
			end
			if (cmd.shift) begin
				wv_s1 <= shift_more;
				wa_s1 <= is_alloc ? sk_q[AW-1:0] : sk_m1[AW-1:0];
				if (shift_more) begin
					sk_q <= is_alloc ? sk_m1 : sk_q + 1'b1;
				end
				if (shift_done) begin
					total_q <= is_alloc ? total_q + 1'b1 : total_q - 1'b1;
				end
			end
			if (cmd.finish && mode_q == MODE_CLEAR) begin
				total_q <= '0;
			end
		end
	end

	// request fields, search position and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode_e'(in_mode);
			count_q <= in_count;
			where_q <= in_where;
			pos_q   <= POS_W'(base_q);
		end else if (cmd.scan && dvalid_q && !match && is_alloc && cand_end > pos_q) begin
			pos_q <= cand_end;
		end
		if (cmd.finish) begin
			start_tile  <= (is_alloc && cmd.status == ST_OK) ? pos_q[START_W-1:0] : '0;
			status      <= cmd.status;
			entry_count <= (mode_q == MODE_CLEAR) ? '0 : ENTRY_CNT_W'(total_q);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ffta_checker.sv
`default_nettype none

module ffta_checker #(
	parameter int MAX_REGIONS = ffta_pkg::MAX_REGIONS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [ffta_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import ffta_pkg::*;

	logic [START_W-1:0]     r_start;
	logic [STATUS_W-1:0]    r_status;
	logic [ENTRY_CNT_W-1:0] r_count;

	assign r_start  = m_tdata[START_W-1:0];
	assign r_status = m_tdata[START_W +: STATUS_W];
	assign r_count  = m_tdata[START_W + STATUS_W +: ENTRY_CNT_W];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight: ready drops after every accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a full table reports the full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_status == ST_FULL |-> r_count == ENTRY_CNT_W'(MAX_REGIONS))
		else $error("full status with wrong entry count");

	// a nonzero start only comes with success
	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_start != '0 |-> r_status == ST_OK)
		else $error("start tile set on failed request");

endmodule

bind first_fit_tile_allocator ffta_checker #(
	.MAX_REGIONS (MAX_REGIONS)
) u_ffta_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ffta_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 80;

	// register indexes past the defined list, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	typedef struct packed {
		logic [START_W-1:0]     start;
		status_e                status;
		logic [ENTRY_CNT_W-1:0] entries;
	} alloc_result_t;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_addr = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    s_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]   s_tdata  = '0;
	logic [MODE_W-1:0]       s_tuser  = '0;
	logic                    m_tready = 1'b0;
	wire                     s_tready;
	wire                     m_tvalid;
	wire [OUT_TDATA_W-1:0]   m_tdata;

	// shadow copy of the region table and registers
	int unsigned region_start_q[MAX_REGIONS_DEF];
	int unsigned region_len_q[MAX_REGIONS_DEF];
	int unsigned region_total_q = 0;
	int unsigned base_q         = 0;
	int unsigned limit_q        = 2048;

	alloc_result_t pending_results[$];
	alloc_result_t want;
	int            mismatches    = 0;
	bit            steady        = 1'b0;
	int            stall_left    = 0;
	int            hold_requests = 0;
	int            hold_served   = 0;

	first_fit_tile_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// first-fit search, insert, release and clear on the shadow table
	function automatic alloc_result_t allocate_regions(mode_e mode, int unsigned count,
			int unsigned where);
		alloc_result_t r;
		int unsigned   pos;
		int unsigned   lim;
		int unsigned   idx;
		int unsigned   k;
		int unsigned   tile_end;
		int            hit;
		r.start  = '0;
		r.status = ST_OK;
		case (mode)
			MODE_ALLOC: begin
				pos = base_q;
				lim = (limit_q > TILE_SPACE_DEF) ? TILE_SPACE_DEF : limit_q;
				if (region_total_q >= MAX_REGIONS_DEF) begin
					r.status = ST_FULL;
				end else if (count == 0) begin
					r.status = ST_NOFIT;
				end else begin
					// walk regions until one starts past the candidate gap
					idx = 0;
					while (idx < region_total_q && region_start_q[idx] < pos + count) begin
						tile_end = region_start_q[idx] + region_len_q[idx];
						if (tile_end > pos)
							pos = tile_end;
						idx++;
					end
					if (pos + count > lim) begin
						r.status = ST_NOFIT;
					end else begin
						for (k = region_total_q; k > idx; k--) begin
							region_start_q[k] = region_start_q[k-1];
							region_len_q[k]   = region_len_q[k-1];
						end
						region_start_q[idx] = pos;
						region_len_q[idx]   = count;
						region_total_q++;
						r.start = pos[START_W-1:0];
					end
				end
			end
			MODE_RELEASE: begin
				hit = -1;
				for (idx = 0; idx < region_total_q; idx++)
					if (hit < 0 && region_start_q[idx] == where)
						hit = idx;
				if (hit < 0) begin
					r.status = ST_NOREGION;
				end else begin
					for (k = hit; k + 1 < region_total_q; k++) begin
						region_start_q[k] = region_start_q[k+1];
						region_len_q[k]   = region_len_q[k+1];
					end
					region_total_q--;
				end
			end
			MODE_CLEAR: begin
				region_total_q = 0;
			end
			default: ;
		endcase
		r.entries = region_total_q[ENTRY_CNT_W-1:0];
		return r;
	endfunction

	// idle length for either side: mostly short, a few long
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 16);
		return $urandom_range(30, 120);
	endfunction

	// receiver: random stalls plus an occasional long hold-off on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (hold_served != hold_requests) begin
			m_tready    <= 1'b0;
			stall_left  <= LONG_HOLD;
			hold_served <= hold_served + 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 25)
				stall_left <= pick_gap();
		end
	end

	// result checker against the oldest pending result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[10:0] !== want.start || m_tdata[12:11] !== want.status ||
						m_tdata[18:13] !== want.entries) begin
					if (mismatches < 10)
						$display("result mismatch: start %0d/%0d status %0d/%0d entries %0d/%0d",
							want.start, m_tdata[10:0], want.status, m_tdata[12:11],
							want.entries, m_tdata[18:13]);
					mismatches++;
				end
			end
		end
	end

	// one request word; valid stays up on return so back-to-back words need no gap
	task automatic send_request(mode_e mode, int unsigned count, int unsigned where);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {1'b0, where[10:0], count[11:0]};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(allocate_regions(mode, count, where));
	endtask

	// stop sending until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_BASE)
			base_q = value & 32'h7FF;
		else if (idx == REG_LIMIT)
			limit_q = value & 32'hFFF;
	endtask

	task automatic set_window(int unsigned base, int unsigned limit);
		drain_results();
		write_reg(REG_BASE, base);
		write_reg(REG_LIMIT, limit);
	endtask

	// empty table, zero and oversized counts, first region, unknown position, spare mode
	task automatic test_basic_requests();
		send_request(MODE_CLEAR, 0, 0);
		send_request(MODE_RELEASE, 0, 0);
		send_request(MODE_NOP, 12'hFFF, 11'h7FF);
		send_request(MODE_ALLOC, 0, 0);
		send_request(MODE_ALLOC, 4095, 0);
		send_request(MODE_ALLOC, 16, 0);
		send_request(MODE_ALLOC, 32, 0);
		send_request(MODE_ALLOC, 8, 0);
		send_request(MODE_RELEASE, 0, 0);
		send_request(MODE_ALLOC, 10, 0);
		send_request(MODE_ALLOC, 10, 0);
		send_request(MODE_RELEASE, 0, 2047);
		send_request(MODE_ALLOC, 2048, 0);
		send_request(MODE_CLEAR, 0, 0);
		send_request(MODE_ALLOC, 2048, 0);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_CLEAR, 0, 0);
	endtask

	// base raised over existing regions, limit edges, base past limit, spare indexes
	task automatic test_base_and_limit();
		send_request(MODE_ALLOC, 50, 0);
		set_window(20, 2048);
		send_request(MODE_ALLOC, 10, 0);
		set_window(100, 200);
		send_request(MODE_ALLOC, 100, 0);
		send_request(MODE_ALLOC, 1, 0);
		set_window(300, 200);
		send_request(MODE_ALLOC, 1, 0);
		set_window(2047, 2048);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_ALLOC, 1, 0);
		drain_results();
		write_reg(REG_SPARE2, 12'h5A5);
		write_reg(REG_SPARE3, 12'hA5A);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_RELEASE, 0, 2047);
		send_request(MODE_RELEASE, 0, 0);
		send_request(MODE_CLEAR, 0, 0);
		set_window(0, 4095);
		send_request(MODE_ALLOC, 2048, 0);
		send_request(MODE_CLEAR, 0, 0);
		set_window(0, 2048);
	endtask

	// fill every slot, hit the full status, free one and refill
	task automatic test_table_full();
		for (int i = 0; i < MAX_REGIONS_DEF; i++)
			send_request(MODE_ALLOC, 3, 0);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_RELEASE, 0, 30);
		send_request(MODE_ALLOC, 2, 0);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_RELEASE, 0, 0);
		send_request(MODE_ALLOC, 3, 0);
		send_request(MODE_CLEAR, 0, 0);
	endtask

	// long receiver hold-off while requests keep coming, then a full drain
	task automatic test_output_backpressure();
		drain_results();
		steady = 1'b1;
		hold_requests++;
		for (int i = 0; i < 20; i++) begin
			if (i % 4 == 3)
				send_request(MODE_RELEASE, 0, region_start_q[0]);
			else
				send_request(MODE_ALLOC, $urandom_range(1, 40), 0);
		end
		drain_results();
		steady = 1'b0;
		send_request(MODE_CLEAR, 0, 0);
	endtask

	// fill/drain waves with random content and some noise
	task automatic run_random_phase(int unsigned base, int unsigned limit, int n_items,
			bit quiet);
		int          r;
		mode_e       mode;
		int unsigned count;
		int unsigned where;
		bit          filling;
		set_window(base, limit);
		steady  = quiet;
		filling = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (region_total_q >= MAX_REGIONS_DEF)
				filling = 1'b0;
			else if (region_total_q == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 99) < 2)
				filling = ~filling;
			count = $urandom_range(0, 4095);
			where = $urandom_range(0, 2047);
			r = $urandom_range(0, 99);
			if (r < 2)
				mode = MODE_CLEAR;
			else if (r < 4)
				mode = MODE_NOP;
			else if (r < (filling ? 75 : 30))
				mode = MODE_ALLOC;
			else
				mode = MODE_RELEASE;
			if (mode == MODE_ALLOC) begin
				r = $urandom_range(0, 99);
				if (r < 65)
					count = $urandom_range(1, 48);
				else if (r < 75)
					count = $urandom_range(1, 300);
				else if (r < 90)
					count = $urandom_range(1, 2048);
				else if (r < 95)
					count = 0;
				else
					count = $urandom_range(2048, 4095);
			end else if (mode == MODE_RELEASE && region_total_q > 0 &&
					$urandom_range(0, 99) < 80) begin
				where = region_start_q[$urandom_range(0, region_total_q - 1)];
			end
			send_request(mode, count, where);
		end
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 2048, 300, 1'b0);
		run_random_phase(0, 4095, 200, 1'b0);
		run_random_phase(100, 900, 250, 1'b1);
		run_random_phase(1024, 1100, 200, 1'b0);
		run_random_phase(2000, 2048, 150, 1'b0);
		run_random_phase($urandom_range(0, 2047), $urandom_range(1, 4095), 250, 1'b0);
		run_random_phase(2047, 2048, 60, 1'b0);
		run_random_phase(600, 0, 40, 1'b0);
		run_random_phase(0, 2048, 300, 1'b0);
	endtask

	// run watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_BASE, 0);
		write_reg(REG_LIMIT, 2048);
		test_basic_requests();
		test_base_and_limit();
		test_table_full();
		test_output_backpressure();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> first_fit_tile_allocator.f
hw/rtl/ffta_pkg.sv
hw/rtl/ffta_ctrl.sv
hw/rtl/ffta_dpath.sv
hw/rtl/first_fit_tile_allocator.sv
hw/rtl/ffta_checker.sv
bench/tb_top.sv
